// ----- hdl/bcz_pkg.sv -----
package bcz_pkg;

  // fixed widths of the result fields
  localparam int POINT_W = 18;
  localparam int VEL_W   = 21;
  localparam int ACCEL_W = 23;

  // pipeline split: shared basis stages, then per-axis stages
  localparam int BASIS_STAGES = 3;
  localparam int AXIS_STAGES  = 3;
  localparam int NUM_STAGES   = BASIS_STAGES + AXIS_STAGES;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CTRL0_X,
    REG_CTRL0_Y,
    REG_CTRL1_X,
    REG_CTRL1_Y,
    REG_CTRL2_X,
    REG_CTRL2_Y,
    REG_CTRL3_X,
    REG_CTRL3_Y
  } cfg_reg_e;

  localparam int CTRL0_X_RESET = 50;
  localparam int CTRL0_Y_RESET = 100;
  localparam int CTRL1_X_RESET = 150;
  localparam int CTRL1_Y_RESET = 400;
  localparam int CTRL2_X_RESET = 250;
  localparam int CTRL2_Y_RESET = 100;
  localparam int CTRL3_X_RESET = 450;
  localparam int CTRL3_Y_RESET = 350;

endpackage

// ----- hdl/bcz_if.sv -----
interface bcz_in_if #(
  parameter int T_W = 17
);
  logic           valid;
  logic           ready;
  logic [T_W-1:0] param_t;

  modport source (output valid, output param_t, input ready);
  modport sink (input valid, input param_t, output ready);
endinterface

interface bcz_out_if import bcz_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic        [POINT_W-1:0] point_x;
  logic        [POINT_W-1:0] point_y;
  logic signed [VEL_W-1:0]   vel_x;
  logic signed [VEL_W-1:0]   vel_y;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;

  modport source (
    output valid, output point_x, output point_y, output vel_x, output vel_y,
    output accel_x, output accel_y, input ready
  );
  modport sink (
    input valid, input point_x, input point_y, input vel_x, input vel_y,
    input accel_x, input accel_y, output ready
  );
endinterface

// ----- hdl/bcz_cfg.sv -----
module bcz_cfg import bcz_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_W-1:0]            cfg_index_i,
  input  logic [COORD_BITS-1:0]           cfg_wdata_i,
  output logic [3:0][COORD_BITS-1:0]      ctrl_x_o,
  output logic [3:0][COORD_BITS-1:0]      ctrl_y_o
);

  logic [3:0][COORD_BITS-1:0] ctrl_x_q, ctrl_x_d;
  logic [3:0][COORD_BITS-1:0] ctrl_y_q, ctrl_y_d;

  always_comb begin
    ctrl_x_d = ctrl_x_q;
    ctrl_y_d = ctrl_y_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CTRL0_X: ctrl_x_d[0] = cfg_wdata_i;
        REG_CTRL0_Y: ctrl_y_d[0] = cfg_wdata_i;
        REG_CTRL1_X: ctrl_x_d[1] = cfg_wdata_i;
        REG_CTRL1_Y: ctrl_y_d[1] = cfg_wdata_i;
        REG_CTRL2_X: ctrl_x_d[2] = cfg_wdata_i;
        REG_CTRL2_Y: ctrl_y_d[2] = cfg_wdata_i;
        REG_CTRL3_X: ctrl_x_d[3] = cfg_wdata_i;
        REG_CTRL3_Y: ctrl_y_d[3] = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_x_q[0] <= COORD_BITS'(CTRL0_X_RESET);
      ctrl_y_q[0] <= COORD_BITS'(CTRL0_Y_RESET);
      ctrl_x_q[1] <= COORD_BITS'(CTRL1_X_RESET);
      ctrl_y_q[1] <= COORD_BITS'(CTRL1_Y_RESET);
      ctrl_x_q[2] <= COORD_BITS'(CTRL2_X_RESET);
      ctrl_y_q[2] <= COORD_BITS'(CTRL2_Y_RESET);
      ctrl_x_q[3] <= COORD_BITS'(CTRL3_X_RESET);
      ctrl_y_q[3] <= COORD_BITS'(CTRL3_Y_RESET);
    end else begin
      ctrl_x_q <= ctrl_x_d;
      ctrl_y_q <= ctrl_y_d;
    end
  end

  assign ctrl_x_o = ctrl_x_q;
  assign ctrl_y_o = ctrl_y_q;

endmodule

// ----- hdl/bcz_basis.sv -----
module bcz_basis import bcz_pkg::*; #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic [BASIS_STAGES-1:0]      en_i,
  input  logic [T_FRAC_BITS:0]         param_t_i,
  output logic [T_FRAC_BITS:0]         t_o,
  output logic [T_FRAC_BITS:0]         u_o,
  output logic [2*T_FRAC_BITS:0]       uu_o,
  output logic [2*T_FRAC_BITS:0]       ut_o,
  output logic [2*T_FRAC_BITS:0]       tt_o,
  output logic [3*T_FRAC_BITS:0]       b0_o,
  output logic [3*T_FRAC_BITS:0]       b1_o,
  output logic [3*T_FRAC_BITS:0]       b2_o,
  output logic [3*T_FRAC_BITS:0]       b3_o
);

  localparam int TW  = T_FRAC_BITS + 1;
  localparam int BW2 = 2 * T_FRAC_BITS + 1;
  localparam int BW3 = 3 * T_FRAC_BITS + 1;
  localparam logic [TW-1:0] ONE = TW'(1) << T_FRAC_BITS;

  // stage 1: clamp t to 1.0, form u = 1 - t
  logic [TW-1:0] t1_q, u1_q, t1_d;

  assign t1_d = (param_t_i > ONE) ? ONE : param_t_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      t1_q <= t1_d;
      u1_q <= ONE - t1_d;
    end
  end

  // stage 2: squares and cross term
  logic [TW-1:0]  t2_q, u2_q;
  logic [BW2-1:0] uu2_q, ut2_q, tt2_q;
  logic [BW2:0]   uu2_w, ut2_w, tt2_w;

  assign uu2_w = (BW2+1)'(u1_q) * (BW2+1)'(u1_q);
  assign ut2_w = (BW2+1)'(u1_q) * (BW2+1)'(t1_q);
  assign tt2_w = (BW2+1)'(t1_q) * (BW2+1)'(t1_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      t2_q  <= t1_q;
      u2_q  <= u1_q;
      uu2_q <= uu2_w[BW2-1:0];
      ut2_q <= ut2_w[BW2-1:0];
      tt2_q <= tt2_w[BW2-1:0];
    end
  end

  // stage 3: cubic terms u^3, u^2 t, u t^2, t^3
  logic [TW-1:0]     t3_q, u3_q;
  logic [BW2-1:0]    uu3_q, ut3_q, tt3_q;
  logic [BW3-1:0]    b0_q, b1_q, b2_q, b3_q;
  logic [BW2+TW-1:0] b0_w, b1_w, b2_w, b3_w;

  assign b0_w = (BW2+TW)'(uu2_q) * (BW2+TW)'(u2_q);
  assign b1_w = (BW2+TW)'(uu2_q) * (BW2+TW)'(t2_q);
  assign b2_w = (BW2+TW)'(tt2_q) * (BW2+TW)'(u2_q);
  assign b3_w = (BW2+TW)'(tt2_q) * (BW2+TW)'(t2_q);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      t3_q  <= t2_q;
      u3_q  <= u2_q;
      uu3_q <= uu2_q;
      ut3_q <= ut2_q;
      tt3_q <= tt2_q;
      b0_q  <= b0_w[BW3-1:0];
      b1_q  <= b1_w[BW3-1:0];
      b2_q  <= b2_w[BW3-1:0];
      b3_q  <= b3_w[BW3-1:0];
    end
  end

  assign t_o  = t3_q;
  assign u_o  = u3_q;
  assign uu_o = uu3_q;
  assign ut_o = ut3_q;
  assign tt_o = tt3_q;
  assign b0_o = b0_q;
  assign b1_o = b1_q;
  assign b2_o = b2_q;
  assign b3_o = b3_q;

endmodule

// ----- hdl/bcz_round.sv -----
module bcz_round #(
  parameter int IN_W       = 32,
  parameter int K          = 16,
  parameter int O          = 8,
  parameter int OUT_W      = 18,
  parameter bit OUT_SIGNED = 1'b1
) (
  input  logic signed [IN_W-1:0]  num_i,
  output logic        [OUT_W-1:0] res_o
);

  localparam int LSH = (O > K) ? (O - K) : 0;
  localparam int WW  = IN_W + 1 + LSH;
  localparam logic signed [WW-1:0] HI = OUT_SIGNED ?
      ((WW'(1) <<< (OUT_W - 1)) - WW'(1)) : ((WW'(1) <<< OUT_W) - WW'(1));
  localparam logic signed [WW-1:0] LO = OUT_SIGNED ? -(WW'(1) <<< (OUT_W - 1)) : '0;

  logic signed [WW-1:0] num_ext, scaled, clipped;

  assign num_ext = WW'(num_i);

  generate
    if (K > O) begin : g_rshift
      // round half up, then drop the extra fraction bits
      localparam int S = K - O;
      localparam logic signed [WW-1:0] HALF = WW'(1) <<< (S - 1);
      assign scaled = (num_ext + HALF) >>> S;
    end else begin : g_lshift
      assign scaled = num_ext <<< LSH;
    end
  endgenerate

  always_comb begin
    if (scaled < LO) begin
      clipped = LO;
    end else if (scaled > HI) begin
      clipped = HI;
    end else begin
      clipped = scaled;
    end
  end

  assign res_o = clipped[OUT_W-1:0];

endmodule

// ----- hdl/bcz_axis.sv -----
module bcz_axis import bcz_pkg::*; #(
  parameter int T_FRAC_BITS   = 16,
  parameter int COORD_BITS    = 10,
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic                              clk_i,
  input  logic [AXIS_STAGES-1:0]            en_i,
  input  logic [3:0][COORD_BITS-1:0]        ctrl_i,
  input  logic [T_FRAC_BITS:0]              t_i,
  input  logic [T_FRAC_BITS:0]              u_i,
  input  logic [2*T_FRAC_BITS:0]            uu_i,
  input  logic [2*T_FRAC_BITS:0]            ut_i,
  input  logic [2*T_FRAC_BITS:0]            tt_i,
  input  logic [3*T_FRAC_BITS:0]            b0_i,
  input  logic [3*T_FRAC_BITS:0]            b1_i,
  input  logic [3*T_FRAC_BITS:0]            b2_i,
  input  logic [3*T_FRAC_BITS:0]            b3_i,
  output logic [POINT_W-1:0]                point_o,
  output logic signed [VEL_W-1:0]           vel_o,
  output logic signed [ACCEL_W-1:0]         accel_o
);

  localparam int F    = T_FRAC_BITS;
  localparam int C    = COORD_BITS;
  localparam int TW   = F + 1;
  localparam int BW2  = 2 * F + 1;
  localparam int BW3  = 3 * F + 1;
  localparam int CW   = C + 5;
  localparam int C3W  = C + 2;
  localparam int PP_W = C + 3 * F;
  localparam int VS_W = C + 2 * F + 4;
  localparam int AS_W = C + F + 5;

  // coefficients, refreshed every cycle from the control points
  logic signed [CW-1:0] pe0, pe1, pe2, pe3, d10, d21, d32, s0, s1;
  logic [C3W-1:0]       p1e, p2e;

  assign pe0 = $signed(CW'(ctrl_i[0]));
  assign pe1 = $signed(CW'(ctrl_i[1]));
  assign pe2 = $signed(CW'(ctrl_i[2]));
  assign pe3 = $signed(CW'(ctrl_i[3]));
  assign d10 = pe1 - pe0;
  assign d21 = pe2 - pe1;
  assign d32 = pe3 - pe2;
  assign s0  = d21 - d10;
  assign s1  = d32 - d21;
  assign p1e = C3W'(ctrl_i[1]);
  assign p2e = C3W'(ctrl_i[2]);

  logic [C-1:0]         cp0_q, cp3_q;
  logic [C3W-1:0]       cp1_q, cp2_q;
  logic signed [CW-1:0] cv0_q, cv1_q, cv2_q, ca0_q, ca1_q;

  always_ff @(posedge clk_i) begin
    cp0_q <= ctrl_i[0];
    cp1_q <= (p1e << 1) + p1e;
    cp2_q <= (p2e << 1) + p2e;
    cp3_q <= ctrl_i[3];
    cv0_q <= (d10 <<< 1) + d10;
    cv1_q <= (d21 <<< 2) + (d21 <<< 1);
    cv2_q <= (d32 <<< 1) + d32;
    ca0_q <= (s0 <<< 2) + (s0 <<< 1);
    ca1_q <= (s1 <<< 2) + (s1 <<< 1);
  end

  // stage 4: coefficient times basis
  logic [C+BW3-1:0]          pp0_w, pp3_w;
  logic [C3W+BW3-1:0]        pp1_w, pp2_w;
  logic signed [CW+BW2:0]    vp0_w, vp1_w, vp2_w;
  logic signed [CW+TW:0]     ap0_w, ap1_w;

  assign pp0_w = (C+BW3)'(cp0_q) * (C+BW3)'(b0_i);
  assign pp1_w = (C3W+BW3)'(cp1_q) * (C3W+BW3)'(b1_i);
  assign pp2_w = (C3W+BW3)'(cp2_q) * (C3W+BW3)'(b2_i);
  assign pp3_w = (C+BW3)'(cp3_q) * (C+BW3)'(b3_i);
  assign vp0_w = (CW+BW2+1)'(cv0_q) * (CW+BW2+1)'($signed({1'b0, uu_i}));
  assign vp1_w = (CW+BW2+1)'(cv1_q) * (CW+BW2+1)'($signed({1'b0, ut_i}));
  assign vp2_w = (CW+BW2+1)'(cv2_q) * (CW+BW2+1)'($signed({1'b0, tt_i}));
  assign ap0_w = (CW+TW+1)'(ca0_q) * (CW+TW+1)'($signed({1'b0, u_i}));
  assign ap1_w = (CW+TW+1)'(ca1_q) * (CW+TW+1)'($signed({1'b0, t_i}));

  logic [PP_W-1:0]        pp0_q, pp1_q, pp2_q, pp3_q;
  logic signed [VS_W-1:0] vp0_q, vp1_q, vp2_q;
  logic signed [AS_W-1:0] ap0_q, ap1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp0_q <= pp0_w[PP_W-1:0];
      pp1_q <= pp1_w[PP_W-1:0];
      pp2_q <= pp2_w[PP_W-1:0];
      pp3_q <= pp3_w[PP_W-1:0];
      vp0_q <= vp0_w[VS_W-1:0];
      vp1_q <= vp1_w[VS_W-1:0];
      vp2_q <= vp2_w[VS_W-1:0];
      ap0_q <= ap0_w[AS_W-1:0];
      ap1_q <= ap1_w[AS_W-1:0];
    end
  end

  // stage 5: partial sums, acceleration complete
  logic [PP_W-1:0]        ps01_q, ps23_q;
  logic signed [VS_W-1:0] vs01_q, vs2_q;
  logic signed [AS_W-1:0] as_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ps01_q <= pp0_q + pp1_q;
      ps23_q <= pp2_q + pp3_q;
      vs01_q <= vp0_q + vp1_q;
      vs2_q  <= vp2_q;
      as_q   <= ap0_q + ap1_q;
    end
  end

  // stage 6: final sums, rounding and clipping into the output register
  logic [PP_W-1:0]           psum;
  logic signed [VS_W-1:0]    vsum;
  logic [POINT_W-1:0]        point_r;
  logic [VEL_W-1:0]          vel_r;
  logic [ACCEL_W-1:0]        accel_r;

  assign psum = ps01_q + ps23_q;
  assign vsum = vs01_q + vs2_q;

  bcz_round #(
    .IN_W(PP_W + 1), .K(3 * F), .O(OUT_FRAC_BITS), .OUT_W(POINT_W), .OUT_SIGNED(1'b0)
  ) u_round_point (
    .num_i($signed({1'b0, psum})),
    .res_o(point_r)
  );

  bcz_round #(
    .IN_W(VS_W), .K(2 * F), .O(OUT_FRAC_BITS), .OUT_W(VEL_W), .OUT_SIGNED(1'b1)
  ) u_round_vel (
    .num_i(vsum),
    .res_o(vel_r)
  );

  bcz_round #(
    .IN_W(AS_W), .K(F), .O(OUT_FRAC_BITS), .OUT_W(ACCEL_W), .OUT_SIGNED(1'b1)
  ) u_round_accel (
    .num_i(as_q),
    .res_o(accel_r)
  );

  logic [POINT_W-1:0]        point_q;
  logic signed [VEL_W-1:0]   vel_q;
  logic signed [ACCEL_W-1:0] accel_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      point_q <= point_r;
      vel_q   <= $signed(vel_r);
      accel_q <= $signed(accel_r);
    end
  end

  assign point_o = point_q;
  assign vel_o   = vel_q;
  assign accel_o = accel_q;

endmodule

// ----- hdl/cubic_bezier_point_and_derivatives.sv -----
// Cubic Bezier evaluator. Each transfer on in_i carries a curve parameter t
// (param_t / 2^T_FRAC_BITS, values above 1.0 are clamped to 1.0) and yields one
// transfer on out_o with the point, first and second derivative in x and y,
// rounded half up to OUT_FRAC_BITS fraction bits and clipped to the field
// widths. The four control points sit in eight registers on the cfg write
// port (reset to the start curve 50,100 / 150,400 / 250,100 / 450,350). The
// user must write them only while no item is in flight; the block itself does
// not enforce this. The datapath is a six-stage pipeline: t clamp, squares,
// cubic basis (shared by both axes), coefficient products, partial sums, final
// sum with rounding into the output register. One item is accepted every cycle
// while out_o does not stall; a stall on out_o backs up through per-stage valid
// bits, so in_i keeps accepting as long as some stage ahead of it is empty.
module cubic_bezier_point_and_derivatives import bcz_pkg::*; #(
  parameter int T_FRAC_BITS   = 16,
  parameter int COORD_BITS    = 10,
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [COORD_BITS-1:0]  cfg_wdata_i,
  bcz_in_if.sink                 in_i,
  bcz_out_if.source              out_o
);

  localparam int TW  = T_FRAC_BITS + 1;
  localparam int BW2 = 2 * T_FRAC_BITS + 1;
  localparam int BW3 = 3 * T_FRAC_BITS + 1;

  // per-stage valid bits and ready chain
  logic [NUM_STAGES-1:0] v_q, v_d, stage_rdy;

  always_comb begin
    stage_rdy[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || out_o.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      stage_rdy[i] = !v_q[i] || stage_rdy[i+1];
    end
  end

  always_comb begin
    v_d[0] = stage_rdy[0] ? in_i.valid : v_q[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      v_d[i] = stage_rdy[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_i.ready  = stage_rdy[0];
  assign out_o.valid = v_q[NUM_STAGES-1];

  logic [3:0][COORD_BITS-1:0] ctrl_x, ctrl_y;

  bcz_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_x_o    (ctrl_x),
    .ctrl_y_o    (ctrl_y)
  );

  logic [TW-1:0]  t_b, u_b;
  logic [BW2-1:0] uu_b, ut_b, tt_b;
  logic [BW3-1:0] b0, b1, b2, b3;

  bcz_basis #(.T_FRAC_BITS(T_FRAC_BITS)) u_basis (
    .clk_i     (clk_i),
    .en_i      (stage_rdy[BASIS_STAGES-1:0]),
    .param_t_i (in_i.param_t),
    .t_o       (t_b),
    .u_o       (u_b),
    .uu_o      (uu_b),
    .ut_o      (ut_b),
    .tt_o      (tt_b),
    .b0_o      (b0),
    .b1_o      (b1),
    .b2_o      (b2),
    .b3_o      (b3)
  );

  bcz_axis #(
    .T_FRAC_BITS(T_FRAC_BITS), .COORD_BITS(COORD_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_axis_x (
    .clk_i   (clk_i),
    .en_i    (stage_rdy[NUM_STAGES-1:BASIS_STAGES]),
    .ctrl_i  (ctrl_x),
    .t_i     (t_b),
    .u_i     (u_b),
    .uu_i    (uu_b),
    .ut_i    (ut_b),
    .tt_i    (tt_b),
    .b0_i    (b0),
    .b1_i    (b1),
    .b2_i    (b2),
    .b3_i    (b3),
    .point_o (out_o.point_x),
    .vel_o   (out_o.vel_x),
    .accel_o (out_o.accel_x)
  );

  bcz_axis #(
    .T_FRAC_BITS(T_FRAC_BITS), .COORD_BITS(COORD_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_axis_y (
    .clk_i   (clk_i),
    .en_i    (stage_rdy[NUM_STAGES-1:BASIS_STAGES]),
    .ctrl_i  (ctrl_y),
    .t_i     (t_b),
    .u_i     (u_b),
    .uu_i    (uu_b),
    .ut_i    (ut_b),
    .tt_i    (tt_b),
    .b0_i    (b0),
    .b1_i    (b1),
    .b2_i    (b2),
    .b3_i    (b3),
    .point_o (out_o.point_y),
    .vel_o   (out_o.vel_y),
    .accel_o (out_o.accel_y)
  );

  // an empty output stage means every stage behind it can move
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NUM_STAGES-1] |-> in_i.ready)
    else $error("input stalled with empty output stage");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v_q[0])
    else $error("accepted transfer not held in first stage");

  a_first_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !stage_rdy[0] |=> v_q[0])
    else $error("first stage dropped a stalled item");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !v_q[NUM_STAGES-2] |=> !out_o.valid)
    else $error("result repeated after transfer");

endmodule

// ----- dv/tb_cubic_bezier_point_and_derivatives.sv -----
module tb_cubic_bezier_point_and_derivatives;
  import bcz_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int T_FRAC     = 16;
  localparam int OUT_FRAC   = 8;
  localparam int PT_SHIFT   = 3 * T_FRAC - OUT_FRAC;
  localparam int VEL_SHIFT  = 2 * T_FRAC - OUT_FRAC;
  localparam int ACC_SHIFT  = T_FRAC - OUT_FRAC;
  localparam int NUM_PHASES = 8;
  localparam int PER_PHASE  = 85;
  localparam int HOLD_AT    = 150;
  localparam int HOLD_LEN   = 100;
  localparam int CYCLE_CAP  = 200000;
  localparam logic signed [79:0] T_ONE = 80'sd65536;

  typedef struct packed {
    logic        [POINT_W-1:0] point_x;
    logic        [POINT_W-1:0] point_y;
    logic signed [VEL_W-1:0]   vel_x;
    logic signed [VEL_W-1:0]   vel_y;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
  } bezier_sample_t;

  typedef struct {
    logic [16:0] param;
    bit          typed;
    int          px, py, vx, vy, ax, ay;
  } directed_row_t;

  // default curve, so the endpoints and t above one can be typed in directly
  directed_row_t dir_table [19] = '{
    '{17'h00000, 1'b1, 12800, 25600, 76800, 230400, 0, -921600},
    '{17'h10000, 1'b1, 115200, 89600, 153600, 192000, 153600, 844800},
    '{17'h10001, 1'b1, 115200, 89600, 153600, 192000, 153600, 844800},
    '{17'h1FFFF, 1'b1, 115200, 89600, 153600, 192000, 153600, 844800},
    '{17'h15555, 1'b1, 115200, 89600, 153600, 192000, 153600, 844800},
    '{17'h00001, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h0FFFF, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h08000, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h04000, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h0C000, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h0AAAA, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h05555, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h00002, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h0FFFE, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h05556, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h0AAAB, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h00100, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h0FF00, 1'b0, 0, 0, 0, 0, 0, 0},
    '{17'h07FFF, 1'b0, 0, 0, 0, 0, 0, 0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [9:0]            cfg_wdata_i;

  bcz_in_if #(.T_W(17)) in_if ();
  bcz_out_if            out_if ();

  cubic_bezier_point_and_derivatives dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #10 clk_i = ~clk_i;

  int             curve_x [4];
  int             curve_y [4];
  bezier_sample_t pending_samples [$];
  bit             cur_typed;
  bezier_sample_t cur_want;
  int             err_cnt = 0;
  int             checked_cnt = 0;
  int             sent_cnt = 0;
  int             cycle_cnt = 0;

  function automatic logic signed [79:0] round_sat(input logic signed [79:0] num,
                                                   input int shift, input int width,
                                                   input bit is_signed);
    logic signed [79:0] v, lo, hi;
    v  = (num + (80'sd1 <<< (shift - 1))) >>> shift;
    lo = is_signed ? -(80'sd1 <<< (width - 1)) : 80'sd0;
    hi = is_signed ? (80'sd1 <<< (width - 1)) - 1 : (80'sd1 <<< width) - 1;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic void eval_axis(input int p0, p1, p2, p3,
                                    input logic signed [79:0] t, u,
                                    output logic signed [79:0] pt, vel, acc);
    logic signed [79:0] a, b, c, d;
    a = 80'(p0);
    b = 80'(p1);
    c = 80'(p2);
    d = 80'(p3);
    pt  = round_sat(a*u*u*u + 3*b*u*u*t + 3*c*u*t*t + d*t*t*t, PT_SHIFT, POINT_W, 1'b0);
    vel = round_sat(3*(b-a)*u*u + 6*(c-b)*u*t + 3*(d-c)*t*t, VEL_SHIFT, VEL_W, 1'b1);
    acc = round_sat(6*(c-2*b+a)*u + 6*(d-2*c+b)*t, ACC_SHIFT, ACCEL_W, 1'b1);
  endfunction

  function automatic bezier_sample_t bezier_eval(input logic [16:0] param);
    logic signed [79:0] t, u, pt, vel, acc;
    bezier_sample_t s;
    t = 80'(param);
    if (t > T_ONE) t = T_ONE;
    u = T_ONE - t;
    eval_axis(curve_x[0], curve_x[1], curve_x[2], curve_x[3], t, u, pt, vel, acc);
    s.point_x = pt[POINT_W-1:0];
    s.vel_x   = vel[VEL_W-1:0];
    s.accel_x = acc[ACCEL_W-1:0];
    eval_axis(curve_y[0], curve_y[1], curve_y[2], curve_y[3], t, u, pt, vel, acc);
    s.point_y = pt[POINT_W-1:0];
    s.vel_y   = vel[VEL_W-1:0];
    s.accel_y = acc[ACCEL_W-1:0];
    return s;
  endfunction

  function automatic logic [16:0] rand_param();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: return 17'h00000;
        1: return 17'h00001;
        2: return 17'h0FFFF;
        default: return 17'h10000;
      endcase
    end
    if (pick <= 2) return 17'($urandom_range(0, 131071));
    return 17'($urandom_range(0, 65536));
  endfunction

  task automatic flag_field(input string name, input logic signed [31:0] want,
                            input logic signed [31:0] got);
    err_cnt++;
    $error("%s expected %0d actual %0d", name, want, got);
  endtask

  always @(posedge clk_i) begin : scoreboard
    bezier_sample_t want, got;
    if (in_if.valid && in_if.ready) begin
      want = cur_typed ? cur_want : bezier_eval(in_if.param_t);
      pending_samples = {pending_samples, want};
      sent_cnt++;
    end
    if (out_if.valid && out_if.ready) begin
      got.point_x = out_if.point_x;
      got.point_y = out_if.point_y;
      got.vel_x   = out_if.vel_x;
      got.vel_y   = out_if.vel_y;
      got.accel_x = out_if.accel_x;
      got.accel_y = out_if.accel_y;
      if (pending_samples.size() == 0) begin
        err_cnt++;
        $error("result transfer with no parameter outstanding");
      end else begin
        want = pending_samples.pop_front();
        checked_cnt++;
        if (got.point_x !== want.point_x)
          flag_field("point_x", 32'(want.point_x), 32'(got.point_x));
        if (got.point_y !== want.point_y)
          flag_field("point_y", 32'(want.point_y), 32'(got.point_y));
        if (got.vel_x !== want.vel_x)
          flag_field("vel_x", 32'(want.vel_x), 32'(got.vel_x));
        if (got.vel_y !== want.vel_y)
          flag_field("vel_y", 32'(want.vel_y), 32'(got.vel_y));
        if (got.accel_x !== want.accel_x)
          flag_field("accel_x", 32'(want.accel_x), 32'(got.accel_x));
        if (got.accel_y !== want.accel_y)
          flag_field("accel_y", 32'(want.accel_y), 32'(got.accel_y));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("[cubic_bezier_point_and_derivatives] ERROR");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off so the pipeline backs up
  initial begin : result_sink
    int stall;
    int rx_mode;
    int taken;
    out_if.ready = 1'b0;
    rx_mode = 1;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (taken % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (taken == HOLD_AT) stall = HOLD_LEN;
      else if (rx_mode == 0) stall = 0;
      else stall = $urandom_range(0, 10);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      taken++;
      @(negedge clk_i);
    end
  end

  // entered and left just after a falling edge
  task automatic send_param(input logic [16:0] param, input bit typed,
                            input bezier_sample_t want, input int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.param_t <= param;
    cur_typed     <= typed;
    cur_want      <= want;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val[9:0];
    case (idx)
      REG_CTRL0_X: curve_x[0] = val;
      REG_CTRL0_Y: curve_y[0] = val;
      REG_CTRL1_X: curve_x[1] = val;
      REG_CTRL1_Y: curve_y[1] = val;
      REG_CTRL2_X: curve_x[2] = val;
      REG_CTRL2_Y: curve_y[2] = val;
      REG_CTRL3_X: curve_x[3] = val;
      default:     curve_y[3] = val;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_curve(input int x0, y0, x1, y1, x2, y2, x3, y3);
    write_reg(REG_CTRL0_X, x0);
    write_reg(REG_CTRL0_Y, y0);
    write_reg(REG_CTRL1_X, x1);
    write_reg(REG_CTRL1_Y, y1);
    write_reg(REG_CTRL2_X, x2);
    write_reg(REG_CTRL2_Y, y2);
    write_reg(REG_CTRL3_X, x3);
    write_reg(REG_CTRL3_Y, y3);
    cfg_we_i <= 1'b0;
  endtask

  // lets every outstanding result drain before the curve may change
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (NUM_STAGES + 2) @(negedge clk_i);
  endtask

  function automatic int next_gap(input int mode);
    if (mode == 0) return 0;
    if (mode == 2 && $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  initial begin : stimulus
    directed_row_t  row;
    bezier_sample_t want;
    int             gap_mode;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_CTRL0_X;
    cfg_wdata_i   = '0;
    in_if.valid   = 1'b0;
    in_if.param_t = '0;
    cur_typed     = 1'b0;
    cur_want      = '0;
    curve_x = '{CTRL0_X_RESET, CTRL1_X_RESET, CTRL2_X_RESET, CTRL3_X_RESET};
    curve_y = '{CTRL0_Y_RESET, CTRL1_Y_RESET, CTRL2_Y_RESET, CTRL3_Y_RESET};
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    gap_mode = $urandom_range(0, 2);
    foreach (dir_table[i]) begin
      row = dir_table[i];
      want = '0;
      want.point_x = row.px[POINT_W-1:0];
      want.point_y = row.py[POINT_W-1:0];
      want.vel_x   = row.vx[VEL_W-1:0];
      want.vel_y   = row.vy[VEL_W-1:0];
      want.accel_x = row.ax[ACCEL_W-1:0];
      want.accel_y = row.ay[ACCEL_W-1:0];
      send_param(row.param, row.typed, want, next_gap(gap_mode));
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: set_curve(0, 0, 0, 0, 0, 0, 0, 0);
          2: set_curve(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023);
          // zigzag gives the largest second derivative
          3: set_curve(1023, 0, 0, 1023, 1023, 0, 0, 1023);
          4: set_curve(0, 1023, 1023, 0, 1023, 0, 0, 1023);
          default: set_curve($urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 1023));
        endcase
      end
      gap_mode = $urandom_range(0, 2);
      repeat (PER_PHASE) send_param(rand_param(), 1'b0, '0, next_gap(gap_mode));
    end
    drain();

    $display("%0d curve parameters sent, %0d results checked over %0d control-point sets",
             sent_cnt, checked_cnt, NUM_PHASES);
    $display("covered t at and above one, flat and extreme curves, and a %0d-cycle backup",
             HOLD_LEN);
    if (err_cnt == 0) begin
      $display("[cubic_bezier_point_and_derivatives] OK");
    end else begin
      $display("[cubic_bezier_point_and_derivatives] ERROR");
    end
    $finish;
  end

endmodule
